[rtl/lpfs_pkg.sv]
// Shared types and constants for the length-prefixed frame segmenter.
package lpfs_pkg;

    localparam int BYTE_W = 8;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

endpackage

[rtl/lpfs_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
module lpfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 31
) (
    input  logic                                    i_clk,
    input  logic                                    i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                        i_wr_data,
    input  logic                                    i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                        o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/lpfs_ctrl.sv]
// Frame sequencer: collects payload into the store, then reads it back as a framed byte stream.
module lpfs_ctrl #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [lpfs_pkg::BYTE_W-1:0]             i_data_byte,
    input  logic                                    i_message_end,
    input  logic [lpfs_pkg::BYTE_W-1:0]             i_pad_byte,
    output lpfs_pkg::t_mem_ctl                      o_mem_ctl,
    output logic [((FRAME_BYTES > 2) ? $clog2(FRAME_BYTES - 1) : 1)-1:0] o_wr_addr,
    output logic [lpfs_pkg::BYTE_W-1:0]             o_wr_data,
    output logic [((FRAME_BYTES > 2) ? $clog2(FRAME_BYTES - 1) : 1)-1:0] o_rd_addr,
    input  logic [lpfs_pkg::BYTE_W-1:0]             i_rd_data,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [lpfs_pkg::BYTE_W-1:0]             o_frame_byte,
    output logic                                    o_frame_end,
    output logic                                    o_message_done
);
    import lpfs_pkg::*;

    localparam int PAYLOAD_MAX = FRAME_BYTES - 1;
    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;
    localparam int CW = $clog2(FRAME_BYTES);
    localparam int KW = $clog2(FRAME_BYTES + 1);
    localparam logic [CW-1:0] CNT_LAST = CW'(PAYLOAD_MAX - 1);
    localparam logic [KW-1:0] K_END    = KW'(FRAME_BYTES);
    localparam logic [KW-1:0] K_LAST   = KW'(FRAME_BYTES - 1);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_n, n_n;
    logic              r_done, n_done;
    logic [KW-1:0]     r_ik, n_ik;
    logic              r_fv, n_fv;
    logic [KW-1:0]     r_fk, n_fk;
    logic              r_ovalid, n_ovalid;
    logic [BYTE_W-1:0] r_obyte, n_obyte;
    logic              r_oend, n_oend;
    logic              r_odone, n_odone;

    logic accept;
    logic closing;
    logic out_free;
    logic issue;
    logic move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        out_free = !r_ovalid || i_out_ready;
        accept   = i_in_valid && (r_state == S_IDLE);
        closing  = i_message_end || (r_count == CNT_LAST);
        issue    = (r_state == S_EMIT) && (r_ik != K_END) && (!r_fv || out_free);
        move     = r_fv && out_free;

        n_state  = r_state;
        n_count  = r_count;
        n_n      = r_n;
        n_done   = r_done;
        n_ik     = r_ik;
        n_fv     = r_fv;
        n_fk     = r_fk;
        n_ovalid = r_ovalid;
        n_obyte  = r_obyte;
        n_oend   = r_oend;
        n_odone  = r_odone;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (closing) begin
                        n_state = S_EMIT;
                        n_count = '0;
                        n_n     = r_count + 1'b1;
                        n_done  = i_message_end;
                        n_ik    = '0;
                    end else begin
                        n_count = r_count + 1'b1;
                    end
                end
            end
            S_EMIT: begin
                // all reads issued and the last one handed on: frame is out
                if ((r_ik == K_END) && (!r_fv || out_free)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (issue) begin
            n_ik = r_ik + 1'b1;
            n_fv = 1'b1;
            n_fk = r_ik;
        end else if (move) begin
            n_fv = 1'b0;
        end

        if (move) begin
            n_ovalid = 1'b1;
            if (r_fk == '0) begin
                n_obyte = BYTE_W'(r_n);
            end else if (r_fk <= KW'(r_n)) begin
                n_obyte = i_rd_data;
            end else begin
                n_obyte = i_pad_byte;
            end
            n_oend  = (r_fk == K_LAST);
            n_odone = r_done;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_fv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_fv     <= n_fv;
            r_ovalid <= n_ovalid;
        end
        r_n     <= n_n;
        r_done  <= n_done;
        r_ik    <= n_ik;
        r_fk    <= n_fk;
        r_obyte <= n_obyte;
        r_oend  <= n_oend;
        r_odone <= n_odone;
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_mem_ctl.we = accept;
    assign o_mem_ctl.re = issue;
    assign o_wr_addr    = AW'(r_count);
    assign o_wr_data    = i_data_byte;
    // the count byte reads nothing useful; park the address at zero
    assign o_rd_addr    = (r_ik == '0) ? '0 : AW'(r_ik - 1'b1);

    assign o_out_valid    = r_ovalid;
    assign o_frame_byte   = r_obyte;
    assign o_frame_end    = r_oend;
    assign o_message_done = r_odone;

    a_idle_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_fv)
        else $error("fetch stage busy while idle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_LAST)
        else $error("payload count past frame capacity");

    a_enter_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && closing) |=> (r_state == S_EMIT) && (r_count == '0) && (r_ik == '0))
        else $error("frame start did not clear count and index");

    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fv && (r_fk == K_LAST)) |-> (r_ik == K_END))
        else $error("frame end fetched before all reads issued");

    a_read_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |-> (r_ik < K_END))
        else $error("read issued past frame end");

endmodule

[rtl/length_prefixed_frame_segmenter_top.sv]
// Top level of the length-prefixed frame segmenter: pad register, payload store and sequencer.
// Input: one byte per cycle while a frame's payload is being collected.
// A frame closes on the end flag or when FRAME_BYTES-1 payload bytes are held; after the closing
// request its first byte passes the state, fetch and output registers, then one byte per cycle
// follows while the receiver is ready, FRAME_BYTES in all. Input is held off during read-back.
// Reset (synchronous, active low) clears the count and sets pad_byte to 0xFF; the store keeps
// its contents, and only bytes written for the current frame are sent.
module length_prefixed_frame_segmenter_top #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lpfs_pkg::BYTE_W-1:0] i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [lpfs_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_message_end,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [lpfs_pkg::BYTE_W-1:0] o_frame_byte,
    output logic                        o_frame_end,
    output logic                        o_message_done
);
    import lpfs_pkg::*;

    localparam int PAYLOAD_MAX = FRAME_BYTES - 1;
    localparam int AW = (PAYLOAD_MAX > 1) ? $clog2(PAYLOAD_MAX) : 1;

    logic [BYTE_W-1:0] r_pad;
    t_mem_ctl          mem_ctl;
    logic [AW-1:0]     wr_addr;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [BYTE_W-1:0] rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad <= 8'hFF;
        end else if (i_cfg_wr_en) begin
            r_pad <= i_cfg_wr_data;
        end
    end

    lpfs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_MAX)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (mem_ctl.we),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (mem_ctl.re),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lpfs_ctrl #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_message_end  (i_message_end),
        .i_pad_byte     (r_pad),
        .o_mem_ctl      (mem_ctl),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data),
        .o_rd_addr      (rd_addr),
        .i_rd_data      (rd_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_frame_byte   (o_frame_byte),
        .o_frame_end    (o_frame_end),
        .o_message_done (o_message_done)
    );

endmodule

[tb/lpfs_frame_checker.sv]
// Frame checker: predicts the frame bytes from the accepted requests and compares them.
`timescale 1ns / 100ps

module lpfs_frame_checker #(
    parameter int FRAME_BYTES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [lpfs_pkg::BYTE_W-1:0] i_cfg_wr_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [lpfs_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_message_end,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [lpfs_pkg::BYTE_W-1:0] i_frame_byte,
    input  logic                        i_frame_end,
    input  logic                        i_message_done,
    output int                          o_pending,
    output int                          o_fail_count
);

    localparam int PAYLOAD_MAX = FRAME_BYTES - 1;

    typedef struct packed {
        logic [lpfs_pkg::BYTE_W-1:0] frame_byte;
        logic                        frame_end;
        logic                        message_done;
    } t_frame_beat;

    logic [lpfs_pkg::BYTE_W-1:0] pad_value;
    logic [lpfs_pkg::BYTE_W-1:0] held_bytes [0:PAYLOAD_MAX-1];
    logic [7:0]                  held_count;
    t_frame_beat                 expected_beats [$];
    int                          mismatches = 0;

    always @(posedge i_clk) begin : watch
        t_frame_beat want;
        int          k;
        if (!i_rst_n) begin
            pad_value  = 8'hFF;
            held_count = '0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    mismatches++;
                    $display("%0t: byte mismatch: expected none, actual %02h/%0b/%0b",
                             $time, i_frame_byte, i_frame_end, i_message_done);
                end else begin
                    want = expected_beats.pop_front();
                    if (i_frame_byte !== want.frame_byte || i_frame_end !== want.frame_end ||
                        i_message_done !== want.message_done) begin
                        mismatches++;
                        $display("%0t: byte mismatch: expected %02h/%0b/%0b, actual %02h/%0b/%0b",
                                 $time, want.frame_byte, want.frame_end, want.message_done,
                                 i_frame_byte, i_frame_end, i_message_done);
                    end
                end
            end

            if (i_cfg_wr_en)
                pad_value = i_cfg_wr_data;

            if (i_in_valid && i_in_ready) begin
                if (held_count < PAYLOAD_MAX) begin
                    held_bytes[held_count] = i_data_byte;
                    held_count++;
                end
                // close the frame on the end flag or on a full payload
                if (i_message_end || held_count == PAYLOAD_MAX) begin
                    for (k = 0; k < FRAME_BYTES; k++) begin
                        if (k == 0)
                            want.frame_byte = held_count;
                        else if (k <= held_count)
                            want.frame_byte = held_bytes[k-1];
                        else
                            want.frame_byte = pad_value;
                        want.frame_end    = (k == FRAME_BYTES - 1);
                        want.message_done = i_message_end;
                        expected_beats.push_back(want);
                    end
                    held_count = '0;
                end
            end
        end
        o_pending    <= expected_beats.size();
        o_fail_count <= mismatches;
    end

endmodule

[tb/tb_length_prefixed_frame_segmenter_top.sv]
// Testbench top: drives messages and pad settings into the segmenter and gives the verdict.
`timescale 1ns / 100ps

module tb_length_prefixed_frame_segmenter_top;

    localparam int FRAME_BYTES = 32;
    localparam int PAYLOAD_MAX = FRAME_BYTES - 1;
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 500000;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_wr_en;
    logic [lpfs_pkg::BYTE_W-1:0] cfg_wr_data;
    logic                        in_valid;
    logic                        in_ready;
    logic [lpfs_pkg::BYTE_W-1:0] data_byte;
    logic                        message_end;
    logic                        out_valid;
    logic                        out_ready;
    logic [lpfs_pkg::BYTE_W-1:0] frame_byte;
    logic                        frame_end;
    logic                        message_done;
    int                          pending;
    int                          fail_count;
    logic                        hold_req;
    bit                          steady_send;

    length_prefixed_frame_segmenter_top #(
        .FRAME_BYTES(FRAME_BYTES)
    ) i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_message_end  (message_end),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_frame_byte   (frame_byte),
        .o_frame_end    (frame_end),
        .o_message_done (message_done)
    );

    lpfs_frame_checker #(
        .FRAME_BYTES(FRAME_BYTES)
    ) i_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_data_byte    (data_byte),
        .i_message_end  (message_end),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_frame_byte   (frame_byte),
        .i_frame_end    (frame_end),
        .i_message_done (message_done),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // leaves valid high at the accepting edge so a back-to-back request needs no toggle
    task automatic send_request(input logic [lpfs_pkg::BYTE_W-1:0] value, input logic last);
        int gap;
        gap = steady_send ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= value;
        message_end <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic send_message(input int len);
        int i;
        steady_send = ($urandom_range(0, 4) == 0);
        for (i = 0; i < len; i++)
            send_request(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // hold the sender until every frame has drained, then let the sequencer go idle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (FRAME_BYTES + 8) @(posedge clk);
    endtask

    task automatic write_pad(input logic [lpfs_pkg::BYTE_W-1:0] value);
        cfg_wr_data <= value;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input int budget, input int first_len);
        int sent;
        int len;
        int r;
        send_message(first_len);
        sent = first_len;
        while (sent < budget) begin
            r = $urandom_range(0, 99);
            if (r < 8)
                len = PAYLOAD_MAX;
            else if (r < 12)
                len = 2 * PAYLOAD_MAX;
            else if (r < 18)
                len = PAYLOAD_MAX + 1;
            else if (r < 30)
                len = 1;
            else if (r < 38)
                len = PAYLOAD_MAX - 1;
            else
                len = $urandom_range(2, 12);
            send_message(len);
            sent += len;
            if ($urandom_range(0, 15) == 0)
                settle();
        end
        settle();
    endtask

    initial begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        data_byte   <= '0;
        message_end <= 1'b0;
        hold_req    <= 1'b0;
        steady_send  = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // short messages at the reset pad: one-byte messages, then a three-byte and a two-byte one, byte extremes
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b1);
        send_request(8'h55, 1'b1);
        send_request(8'hAA, 1'b1);
        send_request(8'h01, 1'b0);
        send_request(8'h80, 1'b0);
        send_request(8'h7F, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'h00, 1'b1);
        settle();

        // exact-fill message first, so no empty trailing frame is expected
        write_pad(8'h00);
        run_phase(36, PAYLOAD_MAX);

        // stall the receiver while a long message keeps the input busy
        write_pad(8'($urandom_range(1, 254)));
        hold_req <= 1'b1;
        run_phase(64, 2 * PAYLOAD_MAX);

        write_pad(8'hFF);
        run_phase(36, PAYLOAD_MAX + 1);

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int  run;
        int  gap;
        bit  hold_done;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                run = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                  : $urandom_range(1, 6);
                repeat (run) @(posedge clk);
                gap = pick_gap();
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
rtl/lpfs_pkg.sv
rtl/lpfs_ram.sv
rtl/lpfs_ctrl.sv
rtl/length_prefixed_frame_segmenter_top.sv
tb/lpfs_frame_checker.sv
tb/tb_length_prefixed_frame_segmenter_top.sv
